// File: src/rlh_pkg.sv
`default_nettype none
package rlh_pkg;

  localparam int unsigned NODES_DEF = 6;
  localparam int unsigned BINS_DEF  = 64;

  localparam logic [15:0] BIN_WIDTH_RST = 16'd100;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  typedef enum logic [2:0] {
    ACT_REQUEST  = 3'd0,
    ACT_RESPONSE = 3'd1,
    ACT_TIMEOUT  = 3'd2,
    ACT_CLEAR    = 3'd3,
    ACT_QUERY    = 3'd4
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_LAT,
    ST_ROW_CLR,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_RANK_START,
    ST_DIV_RANK,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_RESULT
  } state_e;

endpackage
`default_nettype wire

// File: src/rlh_req_if.sv
`default_nettype none
interface rlh_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic        kind;
  logic [7:0]  node_id;
  logic [31:0] time_us;
  logic [31:0] numerator;
  logic [31:0] denominator;

  modport source (output valid, action, kind, node_id, time_us, numerator, denominator,
                  input ready);
  modport sink   (input valid, action, kind, node_id, time_us, numerator, denominator,
                  output ready);
endinterface
`default_nettype wire

// File: src/rlh_rsp_if.sv
`default_nettype none
interface rlh_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] percentile_us;
  logic [31:0] sample_count;
  logic [31:0] peak_us;

  modport source (output valid, status, percentile_us, sample_count, peak_us,
                  input ready);
  modport sink   (input valid, status, percentile_us, sample_count, peak_us,
                  output ready);
endinterface
`default_nettype wire

// File: src/rlh_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle, 64 quotient bits.
module rlh_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [63:0]      quotient_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] dvd_q, dvd_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] div_q, div_d;
  logic [32:0] trial;
  logic        ge;

  always_comb begin
    trial  = {rem_q, dvd_q[63]};
    ge     = trial >= {1'b0, div_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? 32'(trial - {1'b0, div_q}) : trial[31:0];
      dvd_d = {dvd_q[62:0], ge};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule
`default_nettype wire

// File: src/rlh_bin_ram.sv
`default_nettype none
module rlh_bin_ram #(
  parameter int unsigned DEPTH = 768,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [31:0]   wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [31:0]        rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: src/request_latency_histogram.sv
// Channel  | Dir | Payload
// req_if   | in  | action, kind, node_id, time_us, numerator, denominator
// rsp_if   | out | status, percentile_us, sample_count, peak_us
// cfg      | in  | cfg_we_i / cfg_wdata_i: bin width in us
//
// One request at a time. Request, timeout, clear and ignored requests go from decode
// straight to the result. A response runs the divider, and the first time a histogram
// row is written after clear it first zeroes that row. A query runs the divider, then
// walks the bins one at a time through the single RAM read port.
// Reset gives an inactive block; clear marks every histogram row empty at once.
// A result holds on rsp_if until taken; no new request is taken meanwhile.
`default_nettype none
module request_latency_histogram
  import rlh_pkg::*;
#(
  parameter int unsigned NODES = NODES_DEF,
  parameter int unsigned BINS  = BINS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rlh_req_if.sink          req_if,
  rlh_rsp_if.source        rsp_if,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  localparam int unsigned HISTS = 2 * NODES;
  localparam int unsigned HW    = $clog2(HISTS);
  localparam int unsigned BW    = $clog2(BINS);
  localparam int unsigned DEPTH = HISTS * BINS;
  localparam int unsigned AW    = $clog2(DEPTH);

  state_e state_q, state_d;

  logic [15:0] width_q;
  logic [15:0] w;

  logic        active_q;
  logic [HISTS-1:0] pending_q;
  logic [HISTS-1:0] row_valid_q;
  logic [31:0] start_q   [HISTS];
  logic [31:0] samples_q [HISTS];
  logic [31:0] max_q     [HISTS];

  logic [2:0]  action_q;
  logic        kind_q;
  logic [7:0]  node_q;
  logic [31:0] time_q, num_q, den_q;
  logic [HW-1:0] h;
  logic        bad;

  logic [31:0] lat_q;
  logic [BW-1:0] bin_q;
  logic [BW-1:0] idx_q;
  logic [63:0] prod_q;
  logic [31:0] rank_q;
  logic [31:0] cum_q;
  logic [32:0] cum_sum;
  logic [31:0] cum_new;
  logic [31:0] bin_val;
  logic [31:0] pct_edge;

  logic        res_status_q;
  logic [31:0] res_pct_q, res_cnt_q, res_max_q;

  logic        div_start;
  logic [63:0] div_dividend;
  logic [31:0] div_divisor;
  logic        div_done;
  logic [63:0] div_quot;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr, row_base;
  logic [31:0]   ram_wdata, ram_rdata;

  assign w        = (width_q == 16'd0) ? 16'd1 : width_q;
  assign h        = HW'(kind_q ? NODES : 0) + HW'(node_q - 8'd1);
  assign bad      = !active_q || node_q == 8'd0 || node_q > 8'(NODES);
  assign row_base = AW'(AW'(h) * AW'(BINS));
  assign bin_val  = row_valid_q[h] ? ram_rdata : 32'd0;
  assign cum_sum  = {1'b0, cum_q} + {1'b0, bin_val};
  assign cum_new  = cum_sum[32] ? 32'hFFFF_FFFF : cum_sum[31:0];
  assign pct_edge = 32'((32'(idx_q) + 32'd1) * 32'(w));

  rlh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  rlh_bin_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    div_start    = 1'b0;
    div_dividend = {32'd0, time_q - start_q[h]};
    div_divisor  = {16'd0, w};
    ram_we       = 1'b0;
    ram_waddr    = AW'(row_base + AW'(bin_q));
    ram_wdata    = bin_val + 32'd1;
    ram_raddr    = AW'(row_base + AW'(idx_q));
    case (state_q)
      ST_IDLE: begin
        if (req_if.valid) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        state_d = ST_RESULT;
        if (action_q != ACT_CLEAR && !bad) begin
          case (action_e'(action_q))
            ACT_RESPONSE: begin
              if (pending_q[h]) begin
                div_start = 1'b1;
                state_d   = ST_DIV_LAT;
              end
            end
            ACT_QUERY: begin
              if (samples_q[h] != 32'd0 && den_q != 32'd0 && num_q <= den_q)
                state_d = ST_RANK_START;
            end
            default: state_d = ST_RESULT;
          endcase
        end
      end
      ST_DIV_LAT: begin
        if (div_done) state_d = row_valid_q[h] ? ST_RMW_RD : ST_ROW_CLR;
      end
      ST_ROW_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(row_base + AW'(idx_q));
        ram_wdata = 32'd0;
        if (idx_q == BW'(BINS - 1)) state_d = ST_RMW_RD;
      end
      ST_RMW_RD: begin
        ram_raddr = AW'(row_base + AW'(bin_q));
        state_d   = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        ram_we = (bin_val != 32'hFFFF_FFFF);
        state_d = ST_RESULT;
      end
      ST_RANK_START: begin
        div_start    = 1'b1;
        div_dividend = prod_q + {32'd0, den_q - 32'd1};
        div_divisor  = den_q;
        state_d      = ST_DIV_RANK;
      end
      ST_DIV_RANK: begin
        if (div_done) state_d = ST_WALK_RD;
      end
      ST_WALK_RD: begin
        state_d = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (cum_new >= rank_q || idx_q == BW'(BINS - 1)) state_d = ST_RESULT;
        else state_d = ST_WALK_RD;
      end
      ST_RESULT: begin
        if (rsp_if.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= BIN_WIDTH_RST;
      active_q    <= 1'b0;
      pending_q   <= '0;
      row_valid_q <= '0;
      for (int i = 0; i < HISTS; i++) begin
        samples_q[i] <= '0;
        max_q[i]     <= '0;
      end
    end else begin
      if (cfg_we_i) width_q <= cfg_wdata_i;
      case (state_q)
        ST_DECODE: begin
          if (action_q == ACT_CLEAR) begin
            active_q    <= 1'b1;
            pending_q   <= '0;
            row_valid_q <= '0;
            for (int i = 0; i < HISTS; i++) begin
              samples_q[i] <= '0;
              max_q[i]     <= '0;
            end
          end else if (!bad) begin
            case (action_e'(action_q))
              ACT_REQUEST:  pending_q[h] <= 1'b1;
              ACT_RESPONSE: pending_q[h] <= 1'b0;
              ACT_TIMEOUT:  pending_q[h] <= 1'b0;
              default:      pending_q[h] <= pending_q[h];
            endcase
          end
        end
        ST_ROW_CLR: begin
          if (idx_q == BW'(BINS - 1)) row_valid_q[h] <= 1'b1;
        end
        ST_RMW_WR: begin
          if (samples_q[h] != 32'hFFFF_FFFF) samples_q[h] <= samples_q[h] + 32'd1;
          if (lat_q > max_q[h]) max_q[h] <= lat_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (req_if.valid) begin
          action_q <= req_if.action;
          kind_q   <= req_if.kind;
          node_q   <= req_if.node_id;
          time_q   <= req_if.time_us;
          num_q    <= req_if.numerator;
          den_q    <= req_if.denominator;
        end
      end
      ST_DECODE: begin
        res_status_q <= STATUS_IGNORED;
        res_pct_q    <= '0;
        res_cnt_q    <= '0;
        res_max_q    <= '0;
        idx_q        <= '0;
        cum_q        <= '0;
        lat_q        <= time_q - start_q[h];
        prod_q       <= 64'(samples_q[h]) * 64'(num_q);
        if (action_q == ACT_CLEAR) begin
          res_status_q <= STATUS_DONE;
        end else if (!bad) begin
          case (action_e'(action_q))
            ACT_REQUEST: begin
              start_q[h]   <= time_q;
              res_status_q <= STATUS_DONE;
            end
            ACT_TIMEOUT:  res_status_q <= STATUS_DONE;
            ACT_QUERY: begin
              res_status_q <= STATUS_DONE;
              res_cnt_q    <= samples_q[h];
              res_max_q    <= max_q[h];
            end
            default: res_status_q <= STATUS_IGNORED;
          endcase
        end
      end
      ST_DIV_LAT: begin
        if (div_done)
          bin_q <= (div_quot >= 64'(BINS)) ? BW'(BINS - 1) : div_quot[BW-1:0];
      end
      ST_ROW_CLR: begin
        idx_q <= (idx_q == BW'(BINS - 1)) ? '0 : idx_q + BW'(1);
      end
      ST_RMW_WR: begin
        res_status_q <= STATUS_DONE;
      end
      ST_DIV_RANK: begin
        if (div_done) rank_q <= div_quot[31:0];
      end
      ST_WALK_CHK: begin
        cum_q <= cum_new;
        if (cum_new >= rank_q || idx_q == BW'(BINS - 1)) res_pct_q <= pct_edge;
        else idx_q <= idx_q + BW'(1);
      end
      default: ;
    endcase
  end

  assign req_if.ready         = (state_q == ST_IDLE);
  assign rsp_if.valid         = (state_q == ST_RESULT);
  assign rsp_if.status        = res_status_q;
  assign rsp_if.percentile_us = res_pct_q;
  assign rsp_if.sample_count  = res_cnt_q;
  assign rsp_if.peak_us       = res_max_q;

endmodule
`default_nettype wire

// File: dv/request_latency_histogram_test.sv
`default_nettype none
module request_latency_histogram_test
  import rlh_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NODES = NODES_DEF;
  localparam int unsigned BINS  = BINS_DEF;
  localparam int unsigned HISTS = 2 * NODES;
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned RANDOM_REQS = 1750;

  typedef struct packed {
    logic [2:0]  action;
    logic        kind;
    logic [7:0]  node_id;
    logic [31:0] time_us;
    logic [31:0] numerator;
    logic [31:0] denominator;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] percentile_us;
    logic [31:0] sample_count;
    logic [31:0] peak_us;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  rlh_req_if req_if ();
  rlh_rsp_if rsp_if ();

  request_latency_histogram dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_if(req_if.sink), .rsp_if(rsp_if.source),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // histogram model
  logic [15:0] bin_width;
  logic        hist_active;
  logic [31:0] start_time [HISTS];
  logic        pending    [HISTS];
  logic [31:0] bin_count  [HISTS][BINS];
  logic [31:0] samples    [HISTS];
  logic [31:0] worst      [HISTS];

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  bit   stim_done = 0;
  bit   hold_sender = 0;
  bit   req_fire = 0;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return v == SAT32 ? v : v + 32'd1;
  endfunction

  function automatic void wipe_histograms();
    for (int h = 0; h < HISTS; h++) begin
      start_time[h] = '0;
      pending[h] = 1'b0;
      samples[h] = '0;
      worst[h] = '0;
      for (int b = 0; b < BINS; b++) bin_count[h][b] = '0;
    end
  endfunction

  function automatic logic [31:0] percentile_of(int h, logic [31:0] num, logic [31:0] den);
    logic [31:0] w;
    logic [63:0] rank;
    logic [31:0] cum;
    logic [31:0] room;
    w = bin_width == 0 ? 32'd1 : {16'd0, bin_width};
    cum = '0;
    if (samples[h] == 0 || den == 0 || num > den) return '0;
    rank = ({32'd0, samples[h]} * {32'd0, num} + {32'd0, den} - 64'd1) / {32'd0, den};
    for (int i = 0; i < BINS; i++) begin
      room = SAT32 - cum;
      cum += bin_count[h][i] > room ? room : bin_count[h][i];
      if ({32'd0, cum} >= rank) return (i + 1) * w;
    end
    return BINS * w;
  endfunction

  function automatic rsp_t predict_response(req_t r);
    rsp_t o;
    int h;
    logic [31:0] lat, w, bin;
    o = '0;
    o.status = STATUS_IGNORED;
    if (r.action == ACT_CLEAR) begin
      wipe_histograms();
      hist_active = 1'b1;
      o.status = STATUS_DONE;
      return o;
    end
    if (r.action > ACT_QUERY || !hist_active || r.node_id < 1 || r.node_id > NODES)
      return o;
    h = r.kind * NODES + (r.node_id - 1);
    case (r.action)
      ACT_REQUEST: begin
        start_time[h] = r.time_us;
        pending[h] = 1'b1;
        o.status = STATUS_DONE;
      end
      ACT_RESPONSE: begin
        if (pending[h]) begin
          lat = r.time_us - start_time[h];
          w = bin_width == 0 ? 32'd1 : {16'd0, bin_width};
          bin = lat / w;
          if (bin >= BINS) bin = BINS - 1;
          bin_count[h][bin] = sat_inc(bin_count[h][bin]);
          samples[h] = sat_inc(samples[h]);
          if (lat > worst[h]) worst[h] = lat;
          pending[h] = 1'b0;
          o.status = STATUS_DONE;
        end
      end
      ACT_TIMEOUT: begin
        pending[h] = 1'b0;
        o.status = STATUS_DONE;
      end
      default: begin
        o.percentile_us = percentile_of(h, r.numerator, r.denominator);
        o.sample_count = samples[h];
        o.peak_us = worst[h];
        o.status = STATUS_DONE;
      end
    endcase
    return o;
  endfunction

  // request taken at the last rising edge
  always @(posedge clk_i) req_fire <= req_if.valid && req_if.ready;

  // sender: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.action <= '0;
      req_if.kind <= '0;
      req_if.node_id <= '0;
      req_if.time_us <= '0;
      req_if.numerator <= '0;
      req_if.denominator <= '0;
    end else if (!req_if.valid || req_fire) begin
      if (req_fire) void'(pending_reqs.pop_front());
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !hold_sender) begin
        {req_if.action, req_if.kind, req_if.node_id, req_if.time_us, req_if.numerator,
         req_if.denominator} <= pending_reqs[0];
        req_if.valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern runs in phases
  int stall_mode = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= $urandom_range(0, 3) != 0;
        default: rsp_if.ready <= $urandom_range(0, 4) == 0;
      endcase
    end
  end

  // prediction on request, check on result
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    rsp_t got, want;
    req_t r;
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (req_if.valid && req_if.ready) begin
        r = {req_if.action, req_if.kind, req_if.node_id, req_if.time_us,
             req_if.numerator, req_if.denominator};
        expected_rsps.push_back(predict_response(r));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got = {rsp_if.status, rsp_if.percentile_us, rsp_if.sample_count, rsp_if.peak_us};
        if (expected_rsps.size() == 0) begin
          $error("result with nothing expected: status=%0d", got.status);
          errors++;
        end else begin
          want = expected_rsps.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
          if (got.percentile_us !== want.percentile_us) begin
            $error("percentile_us: expected %0d, got %0d", want.percentile_us,
                   got.percentile_us);
            errors++;
          end
          if (got.sample_count !== want.sample_count) begin
            $error("sample_count: expected %0d, got %0d", want.sample_count,
                   got.sample_count);
            errors++;
          end
          if (got.peak_us !== want.peak_us) begin
            $error("peak_us: expected %0d, got %0d", want.peak_us, got.peak_us);
            errors++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic req_t make_req(logic [2:0] a, logic k, logic [7:0] n, logic [31:0] t,
                                    logic [31:0] num, logic [31:0] den);
    req_t r;
    r.action = a; r.kind = k; r.node_id = n; r.time_us = t;
    r.numerator = num; r.denominator = den;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_bin_width(logic [15:0] w);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    bin_width = w;
  endtask

  function automatic logic [7:0] pick_node();
    return ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(1, NODES));
  endfunction

  function automatic logic [31:0] pick_lat();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 200);
      1: return $urandom_range(0, 8000);
      2: return $urandom;
      default: return $urandom_range(0, 3000);
    endcase
  endfunction

  task automatic queue_query(logic k, logic [7:0] n);
    logic [31:0] den, num;
    case ($urandom_range(0, 5))
      0: begin den = $urandom; num = $urandom; end
      1: begin den = 0; num = $urandom; end
      2: begin den = $urandom_range(1, 100); num = den; end
      default: begin den = $urandom_range(1, 1000); num = $urandom_range(0, den); end
    endcase
    pending_reqs.push_back(make_req(ACT_QUERY, k, n, $urandom, num, den));
  endtask

  initial begin
    logic [31:0] t0;
    logic k;
    logic [7:0] n;
    int sent;
    bin_width = BIN_WIDTH_RST;
    hist_active = 1'b0;
    wipe_histograms();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // inactive block ignores all but clear
    pending_reqs.push_back(make_req(ACT_REQUEST, 0, 1, 5, 0, 0));
    pending_reqs.push_back(make_req(ACT_QUERY, 0, 1, 0, 1, 2));
    pending_reqs.push_back(make_req(ACT_CLEAR, 1, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(ACT_RESPONSE, 0, 1, 9, 0, 0));  // not pending
    pending_reqs.push_back(make_req(ACT_TIMEOUT, 1, 2, 0, 0, 0));   // not pending
    pending_reqs.push_back(make_req(ACT_REQUEST, 0, 0, 1, 0, 0));   // node 0
    pending_reqs.push_back(make_req(ACT_REQUEST, 1, 8'hFF, 1, 0, 0));
    pending_reqs.push_back(make_req(ACT_REQUEST, 1, 8'(NODES + 1), 1, 0, 0));
    pending_reqs.push_back(make_req(3'd5, 0, 1, 0, 0, 0));
    pending_reqs.push_back(make_req(3'd7, 1, 1, SAT32, SAT32, SAT32));
    // wrapped latency and last-bin clamp
    pending_reqs.push_back(make_req(ACT_REQUEST, 1, 8'(NODES), SAT32, 0, 0));
    pending_reqs.push_back(make_req(ACT_RESPONSE, 1, 8'(NODES), 32'd50, 0, 0));
    pending_reqs.push_back(make_req(ACT_REQUEST, 0, 1, 0, 0, 0));
    pending_reqs.push_back(make_req(ACT_RESPONSE, 0, 1, SAT32, 0, 0));
    pending_reqs.push_back(make_req(ACT_REQUEST, 0, 1, 100, 0, 0));
    pending_reqs.push_back(make_req(ACT_TIMEOUT, 0, 1, 0, 0, 0));
    pending_reqs.push_back(make_req(ACT_RESPONSE, 0, 1, 200, 0, 0));
    pending_reqs.push_back(make_req(ACT_QUERY, 0, 1, 0, SAT32, SAT32));
    pending_reqs.push_back(make_req(ACT_QUERY, 0, 1, 0, 0, SAT32));
    pending_reqs.push_back(make_req(ACT_QUERY, 0, 1, 0, 2, 1));
    pending_reqs.push_back(make_req(ACT_QUERY, 0, 1, 0, 1, 0));
    pending_reqs.push_back(make_req(ACT_QUERY, 1, 8'(NODES), 0, 1, 2));
    pending_reqs.push_back(make_req(ACT_QUERY, 1, 3, 0, 1, 2));     // empty histogram
    wait_drained();

    sent = 0;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_bin_width(16'd1);
        1: set_bin_width(16'hFFFF);
        2: set_bin_width(16'd0);
        3: set_bin_width(16'd37);
        4: set_bin_width(16'($urandom_range(1, 500)));
        5: set_bin_width(16'($urandom));
        default: set_bin_width(BIN_WIDTH_RST);
      endcase
      if ($urandom_range(0, 2) == 0) pending_reqs.push_back(make_req(ACT_CLEAR, 0, 0, 0, 0, 0));
      while (sent < (phase + 1) * RANDOM_REQS / 7) begin
        k = 1'($urandom_range(0, 1));
        n = pick_node();
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: begin
            // well-formed request/response pair
            t0 = $urandom;
            pending_reqs.push_back(make_req(ACT_REQUEST, k, n, t0, $urandom, $urandom));
            pending_reqs.push_back(make_req(ACT_RESPONSE, k, n, t0 + pick_lat(),
                                            $urandom, $urandom));
            sent += 2;
          end
          9, 10, 11, 12, 13: begin queue_query(k, n); sent++; end
          14: begin
            pending_reqs.push_back(make_req(ACT_CLEAR, k, n, $urandom, $urandom, $urandom));
            sent++;
          end
          15: begin
            pending_reqs.push_back(make_req(ACT_TIMEOUT, k, n, $urandom, 0, 0));
            sent++;
          end
          default: begin
            pending_reqs.push_back(make_req(3'($urandom_range(0, 7)), k, n, $urandom,
                                            $urandom, $urandom));
            sent++;
          end
        endcase
        if ($urandom_range(0, 299) == 0) begin
          // hold off until every result is back
          while (pending_reqs.size() > 0 || req_if.valid) @(posedge clk_i);
          hold_sender = 1;
          while (expected_rsps.size() > 0) @(posedge clk_i);
          hold_sender = 0;
        end
      end
      wait_drained();
    end

    hold_sender = 1;
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (errors == 0 && expected_rsps.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
src/rlh_pkg.sv
src/rlh_req_if.sv
src/rlh_rsp_if.sv
src/rlh_div.sv
src/rlh_bin_ram.sv
src/request_latency_histogram.sv
dv/request_latency_histogram_test.sv
